// ----- rtl/lfp_pkg.sv -----
package lfp_pkg;

	// Operation codes on the kind input
	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_FLUSH = 2'd2,
		KIND_STOP  = 2'd3
	} kind_t;

	// Result status codes
	localparam logic [1:0] ST_SUCCESS = 2'd0;
	localparam logic [1:0] ST_AGAIN   = 2'd1;
	localparam logic [1:0] ST_STOP    = 2'd2;
	localparam logic [1:0] ST_NOMEM   = 2'd3;

	localparam int IO_DATA_W = 32;

	// Control from the sequencer to the node memory
	typedef struct packed {
		logic rd_en;
		logic link_we;
		logic data_we;
	} mem_cmd_t;

endpackage

// ----- rtl/lfp_mem.sv -----
module lfp_mem
	import lfp_pkg::*;
#(
	parameter int POOL_NODES = 18,
	parameter int PTR_W      = 5,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mem_cmd_t              cmd,
	input  logic [PTR_W-1:0]      rd_addr,
	input  logic [PTR_W-1:0]      link_waddr,
	input  logic [PTR_W-1:0]      link_wdata,
	input  logic [PTR_W-1:0]      data_waddr,
	input  logic [DATA_WIDTH-1:0] data_wdata,
	output logic                  init_busy,
	output logic [PTR_W-1:0]      link_rdata,
	output logic [DATA_WIDTH-1:0] data_rdata
);

	logic [PTR_W-1:0]      link_mem [POOL_NODES];
	logic [DATA_WIDTH-1:0] data_mem [POOL_NODES];

	logic             init_busy_q;
	logic [PTR_W-1:0] init_idx_q;

	logic             lw_en;
	logic [PTR_W-1:0] lw_addr;
	logic [PTR_W-1:0] lw_data;

	// init sweep: builds the free chain i -> i+1 after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_busy_q <= 1'b1;
			init_idx_q  <= '0;
		end else if (init_busy_q) begin
			if (init_idx_q == PTR_W'(POOL_NODES - 1)) begin
				init_busy_q <= 1'b0;
			end else begin
				init_idx_q <= init_idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		lw_en   = init_busy_q | cmd.link_we;
		lw_addr = init_busy_q ? init_idx_q : link_waddr;
		lw_data = init_busy_q ? (init_idx_q + 1'b1) : link_wdata;
	end

	always_ff @(posedge clk) begin
		if (lw_en) begin
			link_mem[lw_addr] <= lw_data;
		end
		if (cmd.data_we) begin
			data_mem[data_waddr] <= data_wdata;
		end
		if (cmd.rd_en) begin
			link_rdata <= link_mem[rd_addr];
			data_rdata <= data_mem[rd_addr];
		end
	end

	assign init_busy = init_busy_q;

endmodule

// ----- rtl/linked_list_fifo_with_free_pool_top.sv -----
// Linked-list FIFO over a fixed pool of CAPACITY+2 nodes, with a free list.
// Command channel: drive kind/data_in/prior_status and raise start; the item
// is taken at a clock edge where start is high and busy is low.
// kind: push, pop, flush step, stop. Each item gives exactly one result.
// Result channel: status, data_out, data_valid are valid for the single cycle
// in which done is high; there is no backpressure, the receiver must take it.
// Sequence: busy stays high while an item executes, so the block takes no new
// item before it has finished with the last. The accepting edge reads the link
// and word of the free head (push) or the queue head (other kinds) from the node
// memory (synchronous read); the next edge writes the links back, updates the
// list pointers and raises done.
// Reset: arst_n sets the pointers to their initial values and clears the stop
// flag at once; then an init sweep writes the free chain into the link memory,
// busy stays high during that sweep and no item is taken.
// Both lists keep one dummy node, so a list is empty when its first and last
// pointers match; no per-node valid bits are kept.
module linked_list_fifo_with_free_pool_top
	import lfp_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           kind,
	input  logic [IO_DATA_W-1:0] data_in,
	input  logic [1:0]           prior_status,
	output logic                 done,
	output logic [1:0]           status,
	output logic [IO_DATA_W-1:0] data_out,
	output logic                 data_valid
);

	localparam int POOL_NODES = CAPACITY + 2;
	localparam int PTR_W      = $clog2(POOL_NODES);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t state_q;

	// list pointers
	logic [PTR_W-1:0] q_first_q, q_last_q, f_first_q, f_last_q;
	logic             stopped_q;

	// latched item
	kind_t                 kind_q;
	logic [DATA_WIDTH-1:0] din_q;
	logic [1:0]            prior_q;

	// result registers
	logic                 done_q;
	logic [1:0]           status_q;
	logic [IO_DATA_W-1:0] dout_q;
	logic                 dvalid_q;

	// memory interface
	mem_cmd_t              cmd;
	logic [PTR_W-1:0]      rd_addr, link_waddr, link_wdata;
	logic                  init_busy;
	logic [PTR_W-1:0]      link_rdata;
	logic [DATA_WIDTH-1:0] data_rdata;

	logic accept;

	// exec-stage decisions
	logic                 do_push, do_pull;
	logic [1:0]           ex_status;
	logic [IO_DATA_W-1:0] ex_dout;

	logic [DATA_WIDTH+IO_DATA_W-1:0] din_ext;
	logic [DATA_WIDTH+IO_DATA_W-1:0] dout_ext;

	assign busy   = init_busy | (state_q == S_EXEC);
	assign accept = start & ~busy;

	assign din_ext  = {{DATA_WIDTH{1'b0}}, data_in};
	assign dout_ext = {{IO_DATA_W{1'b0}}, data_rdata};

	// Work out what the latched item does, using the link/word read last cycle
	always_comb begin
		do_push   = 1'b0;
		do_pull   = 1'b0;
		ex_status = ST_SUCCESS;
		ex_dout   = '0;
		if (kind_q == KIND_STOP) begin
			ex_status = ST_STOP;
		end else if (kind_q == KIND_FLUSH && (prior_q == ST_STOP || prior_q == ST_NOMEM)) begin
			// failing prior status passes straight through
			ex_status = prior_q;
		end else if (stopped_q) begin
			ex_status = ST_STOP;
		end else if (kind_q == KIND_PUSH) begin
			if (f_first_q != f_last_q) begin
				do_push = 1'b1;
			end else begin
				ex_status = ST_NOMEM;
			end
		end else if (q_first_q != q_last_q) begin
			do_pull = 1'b1;
			ex_dout = dout_ext[IO_DATA_W-1:0];
			// flush reports again when the new head is not the tail dummy
			if (kind_q == KIND_FLUSH && link_rdata != q_last_q) begin
				ex_status = ST_AGAIN;
			end
		end
	end

	// Memory control: read at accept, write back in exec
	always_comb begin
		cmd.rd_en   = accept;
		cmd.link_we = (state_q == S_EXEC) & (do_push | do_pull);
		cmd.data_we = (state_q == S_EXEC) & do_push;
		rd_addr     = (kind_t'(kind) == KIND_PUSH) ? f_first_q : q_first_q;
		// push: old tail dummy -> fresh node; pull: free tail -> old head
		link_waddr  = do_push ? q_last_q : f_last_q;
		link_wdata  = do_push ? f_first_q : q_first_q;
	end

	lfp_mem #(
		.POOL_NODES(POOL_NODES),
		.PTR_W     (PTR_W),
		.DATA_WIDTH(DATA_WIDTH)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.link_waddr(link_waddr),
		.link_wdata(link_wdata),
		.data_waddr(q_last_q),
		.data_wdata(din_q),
		.init_busy (init_busy),
		.link_rdata(link_rdata),
		.data_rdata(data_rdata)
	);

	// Sequencer, pointers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			q_first_q <= '0;
			q_last_q  <= '0;
			f_first_q <= PTR_W'(1);
			f_last_q  <= PTR_W'(POOL_NODES - 1);
			stopped_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (kind_q == KIND_STOP) begin
						stopped_q <= 1'b1;
					end
					if (do_push) begin
						f_first_q <= link_rdata;
						q_last_q  <= f_first_q;
					end
					if (do_pull) begin
						q_first_q <= link_rdata;
						f_last_q  <= q_first_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind_t'(kind);
			din_q   <= din_ext[DATA_WIDTH-1:0];
			prior_q <= prior_status;
		end
		if (state_q == S_EXEC) begin
			status_q <= ex_status;
			dout_q   <= ex_dout;
			dvalid_q <= do_pull;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign data_out   = dout_q;
	assign data_valid = dvalid_q;

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy && !done))
		else $error("busy not raised after accepting an item");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("result not delivered two cycles after accept");

	a_valid_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && data_valid) |-> (status == ST_SUCCESS || status == ST_AGAIN))
		else $error("dequeued word with a failing status");

	a_lists_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(q_last_q != f_first_q) && (q_first_q != f_last_q))
		else $error("queue and free list share a node");
`endif

endmodule
